// ----- src/usdf_pkg.sv -----
// ============================================================================
// usdf_pkg
// Shared types and constants for the ustar stream deframer: block layout,
// result kinds, parser phases and the result record.
// ============================================================================
`default_nettype none

package usdf_pkg;

    // Default width of the valid header counter.
    localparam int unsigned COUNT_WIDTH_DEF = 16;

    // Header block layout, as byte offsets within a 512-byte block.
    localparam logic [8:0] OFS_LAST        = 9'd511;
    localparam logic [8:0] OFS_SIZE_FIRST  = 9'd124;
    localparam logic [8:0] OFS_SIZE_LAST   = 9'd135;
    localparam logic [8:0] OFS_TYPE        = 9'd156;
    localparam logic [8:0] OFS_MAGIC_FIRST = 9'd257;
    localparam logic [8:0] OFS_MAGIC_LAST  = 9'd261;

    // Octal digit range and the regular file type flag.
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_SEVEN = 8'h37;
    localparam logic [7:0] TYPE_REG   = 8'h30;
    localparam logic [7:0] TYPE_NUL   = 8'h00;

    // Field widths of one result.
    localparam int unsigned SIZE_W  = 36;
    localparam int unsigned INDEX_W = 16;
    localparam int unsigned TDATA_W = 72;

    // What a result carries.
    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_CONTENT = 2'd1,
        KIND_END     = 2'd2
    } t_kind;

    // Parser phase, one-hot.
    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_CONTENT = 3'b010,
        PH_PADDING = 3'b100
    } t_phase;

    // One result record.
    typedef struct packed {
        t_kind               kind;
        logic [7:0]          data_byte;
        logic [INDEX_W-1:0]  entry_index;
        logic [SIZE_W-1:0]   entry_bytes;
        logic [7:0]          type_flag;
        logic                last_of_entry;
    } t_result;

    // Expected magic character at a position within "ustar".
    function automatic logic [7:0] magic_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h75;  // u
            3'd1:    c = 8'h73;  // s
            3'd2:    c = 8'h74;  // t
            3'd3:    c = 8'h61;  // a
            3'd4:    c = 8'h72;  // r
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- src/ustar_stream_deframer_top.sv -----
// ============================================================================
// ustar_stream_deframer_top
// Deframes an uncompressed ustar tar stream into header, content and
// end-of-archive transactions.
// ============================================================================
// Usage:
//   The slave channel takes one stream byte per transaction in tdata.
//   The master channel carries results: tuser holds the kind (header,
//   content byte, end of archive), tlast marks the final content byte of
//   an entry, and tdata holds the byte, entry index, size and type flag.
//   Only bytes that yield a result produce a master transaction; header
//   bytes, padding and content of non-regular entries are absorbed.
//   Each result is registered in the output stage before master tvalid.
//   Throughput is one byte per cycle while slave tready is high; the
//   parser state registers close the loop from one byte to the next.
//   A two-entry output stage (result register plus skid register) lets
//   the block take a byte while a result waits; slave tready falls only
//   when both entries hold results. After the end-of-archive result
//   every further byte is taken and dropped until reset. Reset returns
//   the parser to the start of a header block and empties the output
//   stage.
// ============================================================================
`default_nettype none

module ustar_stream_deframer_top #(
    parameter int unsigned COUNT_WIDTH = usdf_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Slave channel.
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] stream_byte
    // Master channel.
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [7:0] data_byte, [23:8] entry_index, [59:24] entry size,
    // [67:60] type_flag, [71:68] zero
    output logic [usdf_pkg::TDATA_W-1:0] o_m_axis_tdata,
    output logic [1:0]       o_m_axis_tuser,   // [1:0] kind
    output logic             o_m_axis_tlast    // last_of_entry
);
    import usdf_pkg::*;

    logic    w_accept;
    logic    w_res_valid;
    t_result w_res;

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    w_pop;

    assign o_s_axis_tready = !r_skid_valid;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_pop           = r_out_valid && i_m_axis_tready;

    usdf_parser #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_byte      (i_s_axis_tdata),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // Output stage: the skid entry drains first, a new result fills the
    // free entry.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (w_pop || !r_out_valid) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = w_res;
                n_out_valid = w_res_valid;
            end
        end else if (w_res_valid) begin
            n_skid       = w_res;
            n_skid_valid = 1'b1;
        end
    end

    // Output stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Output stage payload.
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_out.type_flag, r_out.entry_bytes,
                              r_out.entry_index, r_out.data_byte};
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tlast  = r_out.last_of_entry;

    // The skid entry is only ever filled behind a waiting result.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds a result while the output register is empty");

    // Only content transactions carry a byte or an end-of-entry mark.
    a_non_content_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser != KIND_CONTENT)) |->
        (!o_m_axis_tlast && (o_m_axis_tdata[7:0] == 8'h00)))
        else $error("header or end transaction carries content fields");

    // An end-of-archive transaction reports no size and no type flag.
    a_end_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == KIND_END)) |->
        (o_m_axis_tdata[71:24] == 48'h0))
        else $error("end-of-archive transaction carries size or type");

endmodule

`default_nettype wire

// ----- src/usdf_parser.sv -----
// ============================================================================
// usdf_parser
// Block walker for the tar stream: gathers header fields, judges each
// header block and forwards regular content bytes, one byte per cycle while i_accept is high.
// ============================================================================
`default_nettype none

module usdf_parser #(
    parameter int unsigned COUNT_WIDTH = usdf_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [7:0]        i_byte,
    output logic                   o_res_valid,
    output usdf_pkg::t_result      o_res
);
    import usdf_pkg::*;

    logic [8:0]             r_offset,      n_offset;
    t_phase                 r_phase,       n_phase;
    logic [SIZE_W-1:0]      r_size_acc,    n_size_acc;
    logic                   r_stopped,     n_stopped;
    logic                   r_magic_ok,    n_magic_ok;
    logic                   r_name_empty,  n_name_empty;
    logic [7:0]             r_held_type,   n_held_type;
    logic [SIZE_W-1:0]      r_content,     n_content;
    logic [8:0]             r_padding,     n_padding;
    logic [COUNT_WIDTH-1:0] r_count,       n_count;
    logic                   r_ended,       n_ended;

    logic        w_regular;
    logic        w_last;
    logic [8:0]  w_magic_pos;
    logic [8:0]  w_pad_new;

    assign w_regular   = (r_held_type == TYPE_REG) || (r_held_type == TYPE_NUL);
    assign w_last      = (r_content <= SIZE_W'(1));
    assign w_magic_pos = r_offset - OFS_MAGIC_FIRST;
    // Padding up to the next block boundary; a multiple of 512 gives zero.
    assign w_pad_new   = 9'(10'd512 - {1'b0, r_size_acc[8:0]});

    // Next state and result for the byte accepted in this cycle.
    always_comb begin
        logic [31:0] count_ext;
        n_offset     = r_offset;
        n_phase      = r_phase;
        n_size_acc   = r_size_acc;
        n_stopped    = r_stopped;
        n_magic_ok   = r_magic_ok;
        n_name_empty = r_name_empty;
        n_held_type  = r_held_type;
        n_content    = r_content;
        n_padding    = r_padding;
        n_count      = r_count;
        n_ended      = r_ended;
        o_res_valid  = 1'b0;
        o_res        = '0;
        count_ext    = '0;

        if (i_accept && !r_ended) begin
            case (r_phase)
                PH_CONTENT: begin
                    n_content = w_last ? '0 : r_content - SIZE_W'(1);
                    if (w_last) begin
                        n_phase = (r_padding != 9'd0) ? PH_PADDING : PH_HEADER;
                    end
                    n_offset = 9'd0;
                    if (w_regular) begin
                        o_res_valid         = 1'b1;
                        o_res.kind          = KIND_CONTENT;
                        o_res.data_byte     = i_byte;
                        o_res.entry_bytes   = r_size_acc;
                        o_res.type_flag     = r_held_type;
                        o_res.last_of_entry = w_last;
                    end
                end
                PH_PADDING: begin
                    if (r_padding != 9'd0) begin
                        n_padding = r_padding - 9'd1;
                    end
                    if (r_padding <= 9'd1) begin
                        n_phase = PH_HEADER;
                    end
                    n_offset = 9'd0;
                end
                default: begin
                    // Start of a header block: restart field gathering.
                    if (r_offset == 9'd0) begin
                        n_size_acc   = '0;
                        n_stopped    = 1'b0;
                        n_magic_ok   = 1'b1;
                        n_name_empty = (i_byte == 8'h00);
                    end
                    // Octal size digits up to the first non-octal byte.
                    if (r_offset inside {[OFS_SIZE_FIRST:OFS_SIZE_LAST]} && !r_stopped) begin
                        if (i_byte inside {[CHAR_ZERO:CHAR_SEVEN]}) begin
                            n_size_acc = {r_size_acc[SIZE_W-4:0], 3'(i_byte - CHAR_ZERO)};
                        end else begin
                            n_stopped = 1'b1;
                        end
                    end
                    if (r_offset == OFS_TYPE) begin
                        n_held_type = i_byte;
                    end
                    if (r_offset inside {[OFS_MAGIC_FIRST:OFS_MAGIC_LAST]}) begin
                        if (i_byte != magic_char(w_magic_pos[2:0])) begin
                            n_magic_ok = 1'b0;
                        end
                    end

                    // Judge the block on its final byte.
                    if (r_offset != OFS_LAST) begin
                        n_offset = r_offset + 9'd1;
                    end else begin
                        n_offset = 9'd0;
                        if (r_name_empty) begin
                            n_ended    = 1'b1;
                            o_res_valid = 1'b1;
                            o_res.kind  = KIND_END;
                        end else if (r_magic_ok) begin
                            if (r_count != '1) begin
                                n_count = r_count + COUNT_WIDTH'(1);
                            end
                            n_content = r_size_acc;
                            n_padding = w_pad_new;
                            if (r_size_acc != '0) begin
                                n_phase = PH_CONTENT;
                            end else if (w_pad_new != 9'd0) begin
                                n_phase = PH_PADDING;
                            end else begin
                                n_phase = PH_HEADER;
                            end
                            o_res_valid       = 1'b1;
                            o_res.kind        = KIND_HEADER;
                            o_res.entry_bytes = r_size_acc;
                            o_res.type_flag   = r_held_type;
                        end
                    end
                end
            endcase
            // Saturated index of the counter value after this byte.
            count_ext         = 32'(n_count);
            o_res.entry_index = (count_ext > 32'h0000_FFFF) ? 16'hFFFF :
                                count_ext[INDEX_W-1:0];
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset     <= 9'd0;
            r_phase      <= PH_HEADER;
            r_size_acc   <= '0;
            r_stopped    <= 1'b0;
            r_magic_ok   <= 1'b1;
            r_name_empty <= 1'b0;
            r_held_type  <= 8'h00;
            r_content    <= '0;
            r_padding    <= 9'd0;
            r_count      <= '0;
            r_ended      <= 1'b0;
        end else begin
            r_offset     <= n_offset;
            r_phase      <= n_phase;
            r_size_acc   <= n_size_acc;
            r_stopped    <= n_stopped;
            r_magic_ok   <= n_magic_ok;
            r_name_empty <= n_name_empty;
            r_held_type  <= n_held_type;
            r_content    <= n_content;
            r_padding    <= n_padding;
            r_count      <= n_count;
            r_ended      <= n_ended;
        end
    end

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb
// Regression bench for the ustar stream deframer. A directed table of header
// blocks walks the size field, type flag, magic and padding corner cases,
// then randomly built archives follow, and an end-of-archive block closes the
// run. Every accepted byte runs through a local deframing model whose
// results are compared field by field against the master channel.
// ============================================================================

module tb;

    import usdf_pkg::*;

    localparam int unsigned CNT_W       = 16;
    localparam int unsigned DIR_ROWS    = 15;
    localparam int unsigned RAND_BLOCKS = 32;
    localparam int unsigned BYTE_TARGET = 1800;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned DRAIN       = 16;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam logic [39:0] MAGIC_TEXT  = "ustar";
    localparam logic [2:0]  NO_FAULT    = 3'd7;
    localparam logic [7:0]  TYPE_DIR    = 8'h35;
    localparam logic [7:0]  TYPE_LINK   = 8'h31;

    // One directed header block and what follows it.
    typedef struct packed {
        logic [7:0]  name0;    // first name byte
        logic [2:0]  fault;    // magic byte to corrupt, NO_FAULT for none
        logic [15:0] size_v;   // entry size written as octal digits
        logic [3:0]  ndig;     // number of digits in the size field
        logic [7:0]  term;     // byte after the digits when fewer than twelve
        logic [7:0]  tflag;    // type flag byte
        logic        stall;    // hold off the receiver during the content
        logic        typed;    // header result given below, not predicted
        t_result     want;
    } t_row;

    logic        clk;
    logic        rst_n;
    logic        s_valid;
    logic [7:0]  s_data;
    logic        m_ready;
    wire         s_ready;
    wire         m_valid;
    wire [TDATA_W-1:0] m_data;
    wire [1:0]   m_user;
    wire         m_last;

    // Deframing model state.
    logic [8:0]       off_q;
    t_phase           phase_q;
    logic [35:0]      size_acc;
    logic             digits_done;
    logic             magic_ok;
    logic             name_zero;
    logic [7:0]       type_held;
    logic [35:0]      content_cnt;
    logic [8:0]       pad_cnt;
    logic [CNT_W-1:0] hdr_cnt;
    logic             ended;

    t_result     pending_results[$];
    logic [7:0]  blk [512];
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned cycles = 0;
    int unsigned useful_bytes = 0;
    int unsigned hold_left = 0;
    bit          hold_req = 1'b0;
    bit          no_gaps = 1'b0;

    ustar_stream_deframer_top #(
        .COUNT_WIDTH(CNT_W)
    ) i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_data),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (m_data),
        .o_m_axis_tuser (m_user),
        .o_m_axis_tlast (m_last)
    );

    // 2 ns clock.
    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Run limit.
    always @(posedge clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("ustar_stream_deframer_top regression: fail");
            $finish;
        end
    end

    // Advances the deframing model by one stream byte; returns 1 with the
    // result when the byte produces one.
    function automatic bit deframe_byte(input logic [7:0] b, output t_result r);
        bit regular;
        bit last;
        int p;
        r = '0;
        if (ended) return 1'b0;
        case (phase_q)
            PH_CONTENT: begin
                regular = (type_held == TYPE_REG) || (type_held == TYPE_NUL);
                last = (content_cnt <= 36'd1);
                content_cnt = last ? 36'd0 : content_cnt - 36'd1;
                if (content_cnt == 36'd0) phase_q = (pad_cnt != 9'd0) ? PH_PADDING : PH_HEADER;
                off_q = 9'd0;
                if (!regular) return 1'b0;
                r.kind = KIND_CONTENT;
                r.data_byte = b;
                r.entry_index = hdr_cnt;
                r.entry_bytes = size_acc;
                r.type_flag = type_held;
                r.last_of_entry = last;
                return 1'b1;
            end
            PH_PADDING: begin
                if (pad_cnt != 9'd0) pad_cnt = pad_cnt - 9'd1;
                if (pad_cnt == 9'd0) phase_q = PH_HEADER;
                off_q = 9'd0;
                return 1'b0;
            end
            default: begin
                // Gather the header fields byte by byte.
                if (off_q == 9'd0) begin
                    size_acc = '0;
                    digits_done = 1'b0;
                    magic_ok = 1'b1;
                    name_zero = (b == 8'h00);
                end
                if (off_q >= OFS_SIZE_FIRST && off_q <= OFS_SIZE_LAST && !digits_done) begin
                    if (b >= CHAR_ZERO && b <= CHAR_SEVEN) size_acc = {size_acc[32:0], b[2:0]};
                    else digits_done = 1'b1;
                end
                if (off_q == OFS_TYPE) type_held = b;
                if (off_q >= OFS_MAGIC_FIRST && off_q <= OFS_MAGIC_LAST) begin
                    p = int'(off_q) - int'(OFS_MAGIC_FIRST);
                    if (b != MAGIC_TEXT[8*(4-p) +: 8]) magic_ok = 1'b0;
                end
                if (off_q != OFS_LAST) begin
                    off_q = off_q + 9'd1;
                    return 1'b0;
                end
                // Judge the completed block.
                off_q = 9'd0;
                if (name_zero) begin
                    ended = 1'b1;
                    r.kind = KIND_END;
                    r.entry_index = hdr_cnt;
                    return 1'b1;
                end
                if (!magic_ok) return 1'b0;
                if (hdr_cnt != '1) hdr_cnt = hdr_cnt + 1'b1;
                content_cnt = size_acc;
                pad_cnt = 9'd0 - size_acc[8:0];
                phase_q = (content_cnt != 36'd0) ? PH_CONTENT :
                          ((pad_cnt != 9'd0) ? PH_PADDING : PH_HEADER);
                r.kind = KIND_HEADER;
                r.entry_index = hdr_cnt;
                r.entry_bytes = size_acc;
                r.type_flag = type_held;
                return 1'b1;
            end
        endcase
    endfunction

    function automatic t_result hdr_want(input logic [15:0] idx, input logic [35:0] sz,
                                         input logic [7:0] tf);
        t_result w;
        w = '0;
        w.kind = KIND_HEADER;
        w.entry_index = idx;
        w.entry_bytes = sz;
        w.type_flag = tf;
        return w;
    endfunction

    // Directed header blocks.
    function automatic t_row dir_row(input int i);
        t_row rw;
        rw = '0;
        case (i)
            // Typical regular file of one byte, eleven digits and a NUL.
            0:  rw = '{8'h61, NO_FAULT, 16'd1, 4'd11, 8'h00, TYPE_REG, 1'b0, 1'b1,
                       hdr_want(16'd1, 36'd1, TYPE_REG)};
            // Zero size with NUL type flag: the next byte is a header.
            1:  rw = '{8'hff, NO_FAULT, 16'd0, 4'd11, 8'h20, TYPE_NUL, 1'b0, 1'b1,
                       hdr_want(16'd2, 36'd0, TYPE_NUL)};
            // All twelve digits taken, a whole block of content, no padding.
            2:  rw = '{8'h01, NO_FAULT, 16'd512, 4'd12, 8'h00, TYPE_REG, 1'b0, 1'b1,
                       hdr_want(16'd3, 36'd512, TYPE_REG)};
            3:  rw = '{8'h41, NO_FAULT, 16'd511, 4'd3, 8'h00, TYPE_REG, 1'b0, 1'b0, '0};
            4:  rw = '{8'h7a, NO_FAULT, 16'd513, 4'd11, 8'h20, TYPE_NUL, 1'b0, 1'b0, '0};
            // Non-regular entries: content and padding are skipped.
            5:  rw = '{8'h64, NO_FAULT, 16'd3, 4'd11, 8'h00, TYPE_DIR, 1'b0, 1'b0, '0};
            6:  rw = '{8'h2e, NO_FAULT, 16'd700, 4'd4, 8'h00, 8'hff, 1'b0, 1'b0, '0};
            // Broken magic at the first and the last character.
            7:  rw = '{8'h62, 3'd0, 16'd5, 4'd11, 8'h00, TYPE_REG, 1'b0, 1'b0, '0};
            8:  rw = '{8'h63, 3'd4, 16'd5, 4'd11, 8'h00, TYPE_REG, 1'b0, 1'b0, '0};
            // Size field starting with a non-octal digit.
            9:  rw = '{8'h65, NO_FAULT, 16'd0, 4'd0, 8'h38, TYPE_REG, 1'b0, 1'b0, '0};
            // Digits stop just above and just below the octal range.
            10: rw = '{8'h66, NO_FAULT, 16'd10, 4'd2, 8'h38, TYPE_REG, 1'b0, 1'b0, '0};
            11: rw = '{8'h67, NO_FAULT, 16'd7, 4'd1, 8'h2f, TYPE_REG, 1'b0, 1'b0, '0};
            12: rw = '{8'h6c, NO_FAULT, 16'd7, 4'd12, 8'h00, TYPE_LINK, 1'b0, 1'b0, '0};
            13: rw = '{8'h80, NO_FAULT, 16'd2, 4'd11, 8'hff, TYPE_NUL, 1'b0, 1'b0, '0};
            // Long regular entry while the receiver holds off.
            default: rw = '{8'h78, NO_FAULT, 16'd1000, 4'd11, 8'h00, TYPE_REG, 1'b1, 1'b0, '0};
        endcase
        return rw;
    endfunction

    function automatic logic [7:0] rand_non_octal();
        logic [7:0] b;
        do b = 8'($urandom_range(255));
        while (b >= CHAR_ZERO && b <= CHAR_SEVEN);
        return b;
    endfunction

    // Builds a header block with random filler around the parsed fields.
    task automatic build_header(input logic [7:0] name0, input logic [2:0] fault,
                                input logic [35:0] size_v, input int nd,
                                input logic [7:0] term, input logic [7:0] tflag);
        for (int i = 0; i < 512; i++) blk[i] = 8'($urandom_range(255));
        blk[0] = name0;
        for (int d = 0; d < nd; d++)
            blk[OFS_SIZE_FIRST + d] = CHAR_ZERO | 8'((size_v >> (3 * (nd - 1 - d))) & 36'd7);
        if (nd < 12) blk[OFS_SIZE_FIRST + nd] = term;
        blk[OFS_TYPE] = tflag;
        for (int p = 0; p < 5; p++) blk[OFS_MAGIC_FIRST + p] = MAGIC_TEXT[8*(4-p) +: 8];
        if (fault != NO_FAULT)
            blk[OFS_MAGIC_FIRST + fault] = blk[OFS_MAGIC_FIRST + fault] ^
                                           8'($urandom_range(255, 1));
    endtask

    // Offers one byte, with random gaps, until a transaction takes it.
    task automatic send_byte(input logic [7:0] b, input bit take_typed, input t_result typed);
        t_result r;
        if (deframe_byte(b, r))
            pending_results.insert(pending_results.size(), take_typed ? typed : r);
        @(negedge clk);
        while (!no_gaps && $urandom_range(99) < 25) begin
            s_valid <= 1'b0;
            s_data <= 8'($urandom_range(255));
            @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data <= b;
        do @(posedge clk);
        while (!s_ready);
    endtask

    task automatic send_block(input bit take_typed, input t_result typed);
        for (int i = 0; i < 512; i++) send_byte(blk[i], take_typed && (i == 511), typed);
    endtask

    // Content bytes followed by padding up to the block boundary.
    task automatic send_body(input int unsigned size_v);
        int unsigned pad;
        pad = (512 - size_v % 512) % 512;
        for (int unsigned i = 0; i < size_v + pad; i++)
            send_byte(8'($urandom_range(255)), 1'b0, '0);
    endtask

    // One random block: mostly well-formed entries, some noise and bad magic.
    task automatic random_block();
        int unsigned pick;
        int unsigned sel;
        int unsigned size_v;
        int unsigned need;
        int unsigned nd;
        logic [7:0] name0;
        logic [7:0] term;
        logic [7:0] tflag;
        logic [2:0] fault;
        pick = $urandom_range(99);
        name0 = 8'($urandom_range(255, 1));
        if (pick < 8) begin
            for (int i = 0; i < 512; i++) blk[i] = 8'($urandom_range(255));
            blk[0] = name0;
            send_block(1'b0, '0);
            useful_bytes += 512;
            return;
        end
        sel = $urandom_range(99);
        if (sel < 15) size_v = 0;
        else if (sel < 50) size_v = $urandom_range(16, 1);
        else if (sel < 65) size_v = 511 + $urandom_range(2);
        else size_v = $urandom_range(1100, 17);
        need = 1;
        while ((size_v >> (3 * need)) != 0) need++;
        nd = $urandom_range(12, need);
        sel = $urandom_range(2);
        term = (sel == 0) ? 8'h00 : ((sel == 1) ? 8'h20 : rand_non_octal());
        sel = $urandom_range(99);
        tflag = (sel < 45) ? TYPE_REG : ((sel < 70) ? TYPE_NUL : 8'($urandom_range(255)));
        fault = (pick < 16) ? 3'($urandom_range(4)) : NO_FAULT;
        build_header(name0, fault, 36'(size_v), nd, term, tflag);
        send_block(1'b0, '0);
        useful_bytes += 512;
        if (fault == NO_FAULT) begin
            send_body(size_v);
            if (tflag == TYPE_REG || tflag == TYPE_NUL) useful_bytes += size_v;
        end
    endtask

    // Receiver: random backpressure plus one long hold when requested.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= no_gaps || ($urandom_range(99) >= 25);
            end
        end
    end

    // Compare every master transaction with the oldest expected result.
    always @(posedge clk) begin
        t_result got;
        t_result want;
        if (rst_n && m_valid && m_ready) begin
            got.kind = t_kind'(m_user);
            got.data_byte = m_data[7:0];
            got.entry_index = m_data[23:8];
            got.entry_bytes = m_data[59:24];
            got.type_flag = m_data[67:60];
            got.last_of_entry = m_last;
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d unexpected: kind %0d data %h index %0d size %0d",
                             results_seen, got.kind, got.data_byte, got.entry_index,
                             got.entry_bytes);
            end else begin
                want = pending_results.pop_front();
                if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
                    got.entry_index !== want.entry_index ||
                    got.entry_bytes !== want.entry_bytes ||
                    got.type_flag !== want.type_flag ||
                    got.last_of_entry !== want.last_of_entry) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result %0d (expected/actual): kind %0d/%0d data %h/%h ",
                                  "index %0d/%0d size %0d/%0d type %h/%h last %0d/%0d"},
                                 results_seen, want.kind, got.kind, want.data_byte,
                                 got.data_byte, want.entry_index, got.entry_index,
                                 want.entry_bytes, got.entry_bytes, want.type_flag,
                                 got.type_flag, want.last_of_entry, got.last_of_entry);
                end
            end
        end
    end

    // Stimulus.
    initial begin
        t_row rw;
        int unsigned blocks;
        rst_n = 1'b0;
        s_valid = 1'b0;
        s_data = 8'h00;
        off_q = '0;
        phase_q = PH_HEADER;
        size_acc = '0;
        digits_done = 1'b0;
        magic_ok = 1'b1;
        name_zero = 1'b0;
        type_held = '0;
        content_cnt = '0;
        pad_cnt = '0;
        hdr_cnt = '0;
        ended = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table.
        for (int i = 0; i < DIR_ROWS; i++) begin
            rw = dir_row(i);
            build_header(rw.name0, rw.fault, 36'(rw.size_v), int'(rw.ndig), rw.term, rw.tflag);
            send_block(rw.typed, rw.want);
            if (rw.stall) hold_req = 1'b1;
            if (rw.fault == NO_FAULT) send_body(rw.size_v);
        end

        // Random archive content, with one stretch free of gaps.
        blocks = 0;
        while (blocks < RAND_BLOCKS || useful_bytes < BYTE_TARGET) begin
            no_gaps = (blocks >= 10 && blocks < 16);
            random_block();
            blocks++;
        end
        no_gaps = 1'b0;

        // End of archive, then bytes that must be dropped.
        build_header(8'h00, NO_FAULT, 36'($urandom_range(600)), 11, 8'h00, TYPE_REG);
        send_block(1'b0, '0);
        for (int i = 0; i < 64; i++) send_byte(8'($urandom_range(255)), 1'b0, '0);
        @(negedge clk);
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("ustar_stream_deframer_top regression: pass");
        else
            $display("ustar_stream_deframer_top regression: fail");
        $finish;
    end

endmodule
